/* hdl/tcch_pkg.sv */
// ----------------------------------------------------------------------------
// Text console character handler package
// Screen geometry, character codes, register indexes and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package tcch_pkg;

    localparam int COLUMNS  = 80;
    localparam int ROWS     = 25;
    localparam int TAB_STOP = 8;

    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int CHAR_W = 8;
    localparam int CLR_W  = 4;

    localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

    localparam logic [CHAR_W-1:0] CHAR_BS       = 8'd8;
    localparam logic [CHAR_W-1:0] CHAR_TAB      = 8'd9;
    localparam logic [CHAR_W-1:0] CHAR_LF       = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_FF       = 8'd12;
    localparam logic [CHAR_W-1:0] CHAR_CR       = 8'd13;
    localparam logic [CHAR_W-1:0] CHAR_PRINT_LO = 8'd32;
    localparam logic [CHAR_W-1:0] CHAR_PRINT_HI = 8'd126;

    typedef enum logic {
        CFG_TEXT_COLOUR       = 1'b0,
        CFG_BACKGROUND_COLOUR = 1'b1
    } t_cfg_index;

    localparam int OUT_W = 48;

    typedef struct packed {
        logic             cursor_moved;
        logic [COL_W-1:0] cursor_col;
        logic [ROW_W-1:0] cursor_row;
        logic             scroll_up;
        logic             clear_screen;
        logic [7:0]       cell_attr;
        logic [6:0]       cell_char;
        logic [COL_W-1:0] cell_col;
        logic [ROW_W-1:0] cell_row;
        logic             cell_write;
    } t_result;

endpackage

`default_nettype wire

/* hdl/tcch_cursor.sv */
// ----------------------------------------------------------------------------
// Text console cursor logic
// Decodes one character against the current cursor and gives the result.
// ----------------------------------------------------------------------------
`default_nettype none

module tcch_cursor (
    input  wire logic [tcch_pkg::CHAR_W-1:0] i_char,
    input  wire logic [tcch_pkg::ROW_W-1:0]  i_row,
    input  wire logic [tcch_pkg::COL_W-1:0]  i_col,
    input  wire logic [7:0]                  i_attr,
    output tcch_pkg::t_result                o_res
);

    logic [tcch_pkg::ROW_W-1:0] row;
    logic [tcch_pkg::COL_W-1:0] col;
    logic [tcch_pkg::ROW_W-1:0] row_down;
    logic                       at_bottom;
    logic [tcch_pkg::COL_W-1:0] tab_base;
    logic [tcch_pkg::COL_W:0]   tab_target;

    always_comb begin
        row = (i_row > tcch_pkg::LAST_ROW) ? tcch_pkg::LAST_ROW : i_row;
        col = (i_col > tcch_pkg::LAST_COL) ? tcch_pkg::LAST_COL : i_col;
        at_bottom = (row == tcch_pkg::LAST_ROW);
        row_down  = at_bottom ? row : row + 1'b1;
        tab_base  = tcch_pkg::COL_W'((32'(col) / tcch_pkg::TAB_STOP) * tcch_pkg::TAB_STOP);
        tab_target = {1'b0, tab_base} + (tcch_pkg::COL_W + 1)'(tcch_pkg::TAB_STOP);

        o_res = '0;
        o_res.cursor_row = row;
        o_res.cursor_col = col;

        priority if (i_char >= tcch_pkg::CHAR_PRINT_LO && i_char <= tcch_pkg::CHAR_PRINT_HI) begin
            o_res.cell_write   = 1'b1;
            o_res.cell_row     = row;
            o_res.cell_col     = col;
            o_res.cell_char    = i_char[6:0];
            o_res.cell_attr    = i_attr;
            o_res.cursor_moved = 1'b1;
            if (col == tcch_pkg::LAST_COL) begin
                o_res.cursor_col = '0;
                o_res.cursor_row = row_down;
                o_res.scroll_up  = at_bottom;
            end else begin
                o_res.cursor_col = col + 1'b1;
            end
        end else if (i_char == tcch_pkg::CHAR_BS) begin
            if (col != '0) begin
                o_res.cursor_col   = col - 1'b1;
                o_res.cursor_moved = 1'b1;
            end
        end else if (i_char == tcch_pkg::CHAR_TAB) begin
            o_res.cursor_moved = 1'b1;
            if (col != tcch_pkg::LAST_COL) begin
                o_res.cursor_col = (tab_target > {1'b0, tcch_pkg::LAST_COL})
                                   ? tcch_pkg::LAST_COL : tab_target[tcch_pkg::COL_W-1:0];
            end
        end else if (i_char == tcch_pkg::CHAR_LF) begin
            o_res.cursor_col   = '0;
            o_res.cursor_row   = row_down;
            o_res.scroll_up    = at_bottom;
            o_res.cursor_moved = 1'b1;
        end else if (i_char == tcch_pkg::CHAR_FF) begin
            o_res.clear_screen = 1'b1;
            o_res.cursor_row   = '0;
            o_res.cursor_col   = '0;
            o_res.cursor_moved = 1'b1;
        end else if (i_char == tcch_pkg::CHAR_CR) begin
            o_res.cursor_col   = '0;
            o_res.cursor_moved = 1'b1;
        end else begin
            o_res.cursor_moved = 1'b0;
        end
    end

endmodule

`default_nettype wire

/* hdl/text_console_char_handler.sv */
// ----------------------------------------------------------------------------
// Text console character handler
// Keeps a text cursor and turns character bytes into console commands.
// ----------------------------------------------------------------------------
// Input stream: one character byte per word on s_axis_tdata.
// Output stream: one result word per input word on m_axis_tdata, carrying the
// cell write, clear and scroll commands and the new cursor position.
// Configuration: i_cfg_valid with i_cfg_index and i_cfg_data writes the text
// colour (index 0) or background colour (index 1); it is always ready.
// The result word of an accepted character is valid in the next cycle.
// Throughput is one character per cycle unless the output stalls; the cursor
// update is one logic pass from the cursor registers to the result register.
// A new character is taken whenever the result register is empty or is being
// read in the same cycle, so a stalled receiver holds the result and blocks
// the input only while that one result waits.
// Reset homes the cursor to row 0, column 0, sets the text colour to 15 and
// the background to 0, and empties the output.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_char_handler (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: char_code[7:0]
    input  wire logic [tcch_pkg::CHAR_W-1:0]   s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // tdata: cell_write[0], cell_row[5:1], cell_col[12:6], cell_char[19:13],
    // cell_attr[27:20], clear_screen[28], scroll_up[29], cursor_row[34:30],
    // cursor_col[41:35], cursor_moved[42], zero[47:43]
    output logic [tcch_pkg::OUT_W-1:0]         m_axis_tdata,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic                          i_cfg_index,
    input  wire logic [tcch_pkg::CLR_W-1:0]    i_cfg_data
);

    logic [tcch_pkg::ROW_W-1:0] r_row;
    logic [tcch_pkg::COL_W-1:0] r_col;
    logic [tcch_pkg::CLR_W-1:0] r_text;
    logic [tcch_pkg::CLR_W-1:0] r_back;
    logic                       r_out_valid;
    tcch_pkg::t_result          r_res;
    tcch_pkg::t_result          n_res;
    logic                       in_take;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    tcch_cursor u_cursor (
        .i_char (s_axis_tdata),
        .i_row  (r_row),
        .i_col  (r_col),
        .i_attr ({r_back, r_text}),
        .o_res  (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= '0;
            r_col       <= '0;
            r_text      <= 4'd15;
            r_back      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (tcch_pkg::t_cfg_index'(i_cfg_index))
                    tcch_pkg::CFG_TEXT_COLOUR:       r_text <= i_cfg_data;
                    tcch_pkg::CFG_BACKGROUND_COLOUR: r_back <= i_cfg_data;
                    default:                         r_text <= r_text;
                endcase
            end
            if (in_take) begin
                r_row       <= n_res.cursor_row;
                r_col       <= n_res.cursor_col;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_res <= n_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_res};

`ifndef SYNTHESIS
    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_res.cursor_row <= tcch_pkg::LAST_ROW
                         && r_res.cursor_col <= tcch_pkg::LAST_COL))
        else $error("cursor left the screen");

    a_scroll_bottom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.scroll_up) |->
            (r_res.cursor_row == tcch_pkg::LAST_ROW && r_res.cursor_col == '0))
        else $error("scroll without cursor on last row start");

    a_clear_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.clear_screen) |->
            (r_res.cursor_row == '0 && r_res.cursor_col == '0 && !r_res.cell_write))
        else $error("clear without cursor home");

    a_state_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_row == r_res.cursor_row && r_col == r_res.cursor_col))
        else $error("cursor state differs from last result");
`endif

endmodule

`default_nettype wire

/* tb/tb_text_console_char_handler.sv */
// ----------------------------------------------------------------------------
// Testbench for the text console character handler
// Streams character bytes into the block and tracks the cursor, colours and
// console commands in a scoreboard of its own. Every result word is checked
// field by field against the oldest prediction. A directed part covers the
// printable limits, the control codes, ignored codes and tab clamping. Random
// runs of text, newlines, control mixes and noise follow, under four colour
// settings, with random stalls on both streams and one long output hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_text_console_char_handler;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 60;
    localparam int RES_W       = $bits(tcch_pkg::t_result);

    localparam logic [tcch_pkg::CHAR_W-1:0] CTRL_CODES [4] = '{
        tcch_pkg::CHAR_BS, tcch_pkg::CHAR_TAB, tcch_pkg::CHAR_CR, tcch_pkg::CHAR_LF
    };

    class console_tracker;
        logic [tcch_pkg::ROW_W-1:0] row_pos;
        logic [tcch_pkg::COL_W-1:0] col_pos;
        logic [tcch_pkg::CLR_W-1:0] fg_colour;
        logic [tcch_pkg::CLR_W-1:0] bg_colour;
        tcch_pkg::t_result          expected_words[$];
        int                         errors;

        function new();
            row_pos   = '0;
            col_pos   = '0;
            fg_colour = 4'd15;
            bg_colour = 4'd0;
            errors    = 0;
        endfunction

        function void set_reg(tcch_pkg::t_cfg_index idx, logic [tcch_pkg::CLR_W-1:0] val);
            if (idx == tcch_pkg::CFG_TEXT_COLOUR) begin
                fg_colour = val;
            end else begin
                bg_colour = val;
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function void note_char(logic [tcch_pkg::CHAR_W-1:0] c);
            tcch_pkg::t_result r;
            int                row;
            int                col;
            int                tab;
            r   = '0;
            row = int'(row_pos);
            col = int'(col_pos);
            if (row > int'(tcch_pkg::LAST_ROW)) row = int'(tcch_pkg::LAST_ROW);
            if (col > int'(tcch_pkg::LAST_COL)) col = int'(tcch_pkg::LAST_COL);
            if (c >= tcch_pkg::CHAR_PRINT_LO && c <= tcch_pkg::CHAR_PRINT_HI) begin
                r.cell_write = 1'b1;
                r.cell_row   = tcch_pkg::ROW_W'(row);
                r.cell_col   = tcch_pkg::COL_W'(col);
                r.cell_char  = c[6:0];
                r.cell_attr  = {bg_colour, fg_colour};
                if (col == int'(tcch_pkg::LAST_COL)) begin
                    col = 0;
                    if (row + 1 >= tcch_pkg::ROWS) begin
                        row         = tcch_pkg::ROWS - 1;
                        r.scroll_up = 1'b1;
                    end else begin
                        row++;
                    end
                end else begin
                    col++;
                end
                r.cursor_moved = 1'b1;
            end else if (c == tcch_pkg::CHAR_BS) begin
                if (col != 0) begin
                    col--;
                    r.cursor_moved = 1'b1;
                end
            end else if (c == tcch_pkg::CHAR_TAB) begin
                if (col != int'(tcch_pkg::LAST_COL)) begin
                    tab = (col / tcch_pkg::TAB_STOP) * tcch_pkg::TAB_STOP + tcch_pkg::TAB_STOP;
                    col = (tab > int'(tcch_pkg::LAST_COL)) ? int'(tcch_pkg::LAST_COL) : tab;
                end
                r.cursor_moved = 1'b1;
            end else if (c == tcch_pkg::CHAR_LF) begin
                col = 0;
                if (row + 1 >= tcch_pkg::ROWS) begin
                    row         = tcch_pkg::ROWS - 1;
                    r.scroll_up = 1'b1;
                end else begin
                    row++;
                end
                r.cursor_moved = 1'b1;
            end else if (c == tcch_pkg::CHAR_FF) begin
                r.clear_screen = 1'b1;
                row            = 0;
                col            = 0;
                r.cursor_moved = 1'b1;
            end else if (c == tcch_pkg::CHAR_CR) begin
                col            = 0;
                r.cursor_moved = 1'b1;
            end
            row_pos      = tcch_pkg::ROW_W'(row);
            col_pos      = tcch_pkg::COL_W'(col);
            r.cursor_row = row_pos;
            r.cursor_col = col_pos;
            expected_words.push_back(r);
        endfunction

        function void cmp_field(string name, int unsigned exp_v, int unsigned act_v);
            if (exp_v != act_v) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
            end
        endfunction

        function void check_word(logic [tcch_pkg::OUT_W-1:0] w);
            tcch_pkg::t_result act;
            tcch_pkg::t_result exp_r;
            act = tcch_pkg::t_result'(w[RES_W-1:0]);
            if (expected_words.size() == 0) begin
                errors++;
                $display("%0t: result word with nothing expected, expected none actual %h",
                         $time, w);
                return;
            end
            exp_r = expected_words.pop_front();
            cmp_field("cell_write",   32'(exp_r.cell_write),   32'(act.cell_write));
            cmp_field("cell_row",     32'(exp_r.cell_row),     32'(act.cell_row));
            cmp_field("cell_col",     32'(exp_r.cell_col),     32'(act.cell_col));
            cmp_field("cell_char",    32'(exp_r.cell_char),    32'(act.cell_char));
            cmp_field("cell_attr",    32'(exp_r.cell_attr),    32'(act.cell_attr));
            cmp_field("clear_screen", 32'(exp_r.clear_screen), 32'(act.clear_screen));
            cmp_field("scroll_up",    32'(exp_r.scroll_up),    32'(act.scroll_up));
            cmp_field("cursor_row",   32'(exp_r.cursor_row),   32'(act.cursor_row));
            cmp_field("cursor_col",   32'(exp_r.cursor_col),   32'(act.cursor_col));
            cmp_field("cursor_moved", 32'(exp_r.cursor_moved), 32'(act.cursor_moved));
            cmp_field("padding",      0,  32'(w[tcch_pkg::OUT_W-1:RES_W]));
        endfunction
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    logic [tcch_pkg::CHAR_W-1:0]   s_axis_tdata;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    logic [tcch_pkg::OUT_W-1:0]    m_axis_tdata;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    tcch_pkg::t_cfg_index          i_cfg_index;
    logic [tcch_pkg::CLR_W-1:0]    i_cfg_data;

    logic                          idle_on;
    logic                          hold_request;
    int                            quiet_cycles;
    console_tracker                tracker;

    always #1 i_clk = ~i_clk;

    text_console_char_handler u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    task automatic send_char(input logic [tcch_pkg::CHAR_W-1:0] c);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = c;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        tracker.note_char(c);
        @(negedge i_clk);
    endtask

    task automatic pause_until_drained();
        s_axis_tvalid = 1'b0;
        while (tracker.pending() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input tcch_pkg::t_cfg_index idx,
                             input logic [tcch_pkg::CLR_W-1:0] val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        tracker.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_colours(input logic [tcch_pkg::CLR_W-1:0] fg,
                               input logic [tcch_pkg::CLR_W-1:0] bg);
        pause_until_drained();
        write_reg(tcch_pkg::CFG_TEXT_COLOUR, fg);
        write_reg(tcch_pkg::CFG_BACKGROUND_COLOUR, bg);
    endtask

    // Mostly runs of text and newlines that reach the bottom row and scroll,
    // with control mixes, form feeds and noise bytes in between.
    task automatic run_random(input int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    len = $urandom_range(1, 90);
                    repeat (len) send_char(tcch_pkg::CHAR_W'($urandom_range(32, 126)));
                    sent += len;
                end
                4: begin
                    len = $urandom_range(1, 30);
                    repeat (len) send_char(tcch_pkg::CHAR_LF);
                    sent += len;
                end
                5: begin
                    len = $urandom_range(1, 12);
                    repeat (len) send_char(CTRL_CODES[$urandom_range(0, 3)]);
                    sent += len;
                end
                6: begin
                    send_char(tcch_pkg::CHAR_FF);
                    sent++;
                end
                7: begin
                    len = $urandom_range(1, 5);
                    repeat (len) send_char(tcch_pkg::CHAR_W'($urandom_range(0, 255)));
                    sent += len;
                end
                8: begin
                    len = $urandom_range(1, 20);
                    repeat (len) begin
                        if ($urandom_range(0, 2) == 0) begin
                            send_char(CTRL_CODES[$urandom_range(0, 3)]);
                        end else begin
                            send_char(tcch_pkg::CHAR_W'($urandom_range(32, 126)));
                        end
                    end
                    sent += len;
                end
                default: begin
                    repeat (tcch_pkg::ROWS) send_char(tcch_pkg::CHAR_LF);
                    repeat (tcch_pkg::COLUMNS)
                        send_char(tcch_pkg::CHAR_W'($urandom_range(32, 126)));
                    sent += tcch_pkg::ROWS + tcch_pkg::COLUMNS;
                end
            endcase
        end
    endtask

    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request  = 1'b0;
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 7) - 1) @(negedge i_clk);
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            tracker.check_word(m_axis_tdata);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = tcch_pkg::CFG_TEXT_COLOUR;
        i_cfg_data    = '0;
        idle_on       = 1'b1;
        hold_request  = 1'b0;
        quiet_cycles  = 0;
        tracker       = new();
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_char(8'd65);
        send_char(tcch_pkg::CHAR_PRINT_LO);
        send_char(tcch_pkg::CHAR_PRINT_HI);
        send_char(8'd127);
        send_char(8'd0);
        send_char(8'd255);
        send_char(tcch_pkg::CHAR_BS);
        send_char(tcch_pkg::CHAR_CR);
        send_char(tcch_pkg::CHAR_BS);
        // Ten tabs reach the last column through the clamp; the eleventh stays.
        repeat (11) send_char(tcch_pkg::CHAR_TAB);
        send_char(8'd122);
        send_char(tcch_pkg::CHAR_LF);
        send_char(tcch_pkg::CHAR_FF);

        set_colours(4'd0, 4'd15);
        run_random(200);

        set_colours(4'd15, 4'd0);
        hold_request = 1'b1;
        run_random(200);

        set_colours(tcch_pkg::CLR_W'($urandom_range(0, 15)),
                    tcch_pkg::CLR_W'($urandom_range(0, 15)));
        run_random(150);

        pause_until_drained();
        idle_on = 1'b0;
        set_colours(tcch_pkg::CLR_W'($urandom_range(0, 15)),
                    tcch_pkg::CLR_W'($urandom_range(0, 15)));
        run_random(100);

        pause_until_drained();
        repeat (4) @(negedge i_clk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
